[hw/rtl/dss_pkg.sv]
// Shared types and constants of the delayed start slot scheduler.
// Depends on nothing; dss_if, dss_div, the top level and the testbench import it.
package dss_pkg;

   localparam int SLOTS_DEFAULT = 16;

   // Field widths
   localparam int MODE_W   = 2;
   localparam int FLAG_W   = 16;
   localparam int HOST_W   = 32;
   localparam int MS_W     = 16;
   localparam int TEMPO_W  = 16;
   localparam int OFFSET_W = 24;
   localparam int LIMIT_W  = 24;
   localparam int ADV_W    = 16;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 24;
   localparam int RATE_W   = 18;
   localparam int DUE_W    = 40;
   localparam int FRAC_W   = 8;
   localparam int STEP_W   = ADV_W + FRAC_W;

   localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

   // Delay conversion: ms * rate * 2^16 / (1000 * tempo)
   localparam int MS_PER_S = 1000;
   localparam int SCALE_W  = 16;
   localparam int PROD_W   = MS_W + RATE_W;
   localparam int NUM_W    = PROD_W + SCALE_W;
   localparam int DEN_W    = TEMPO_W + 10;

   localparam logic [DUE_W-1:0] DUE_MAX = {1'b0, {(DUE_W-1){1'b1}}};
   localparam logic [DUE_W-1:0] DUE_MIN = {1'b1, {(DUE_W-1){1'b0}}};
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      MODE_QUEUE    = 2'd0,
      MODE_NEXT_DUE = 2'd1,
      MODE_ADVANCE  = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED   = 3'd0,
      ST_FULL     = 3'd1,
      ST_DUE      = 3'd2,
      ST_NONE     = 3'd3,
      ST_ADVANCED = 3'd4,
      ST_CLEARED  = 3'd5
   } status_type;

   typedef struct packed {
      logic [FLAG_W-1:0] flag;
      logic [HOST_W-1:0] host;
      logic [DUE_W-1:0]  due;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

[hw/rtl/dss_if.sv]
// Request and response channel interfaces of the slot scheduler.
// Depends on dss_pkg for the field widths.
interface dss_req_if;
   import dss_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [FLAG_W-1:0]   flag_id;
   logic [HOST_W-1:0]   host_key;
   logic [MS_W-1:0]     delay_ms;
   logic [TEMPO_W-1:0]  tempo_mult;
   logic [OFFSET_W-1:0] start_offset;
   logic [LIMIT_W-1:0]  due_limit;
   logic [ADV_W-1:0]    advance_count;

   modport source (output valid, mode, flag_id, host_key, delay_ms, tempo_mult,
                   start_offset, due_limit, advance_count, input ready);
   modport sink   (input valid, mode, flag_id, host_key, delay_ms, tempo_mult,
                   start_offset, due_limit, advance_count, output ready);
endinterface

interface dss_rsp_if;
   import dss_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FLAG_W-1:0]   out_flag_id;
   logic [HOST_W-1:0]   out_host_key;
   logic [POS_W-1:0]    start_pos;

   modport source (output valid, status, out_flag_id, out_host_key, start_pos,
                   input ready);
   modport sink   (input valid, status, out_flag_id, out_host_key, start_pos,
                   output ready);
endinterface

[hw/rtl/dss_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module dss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/dss_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on dss_pkg for default operand widths.
module dss_div #(
   parameter int NUM_W = dss_pkg::NUM_W,
   parameter int DEN_W = dss_pkg::DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);
   import dss_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         // shift the dividend in from the top of the quotient register
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

[hw/rtl/delayed_start_slot_scheduler.sv]
// Delayed start slot scheduler, top level: sequencer, slot table, result register.
// Depends on dss_pkg, dss_if (channels), dss_ram (slot store) and dss_div.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  req_if   | in  | valid/ready          | mode, flag_id, host_key, delay_ms, tempo_mult,
//           |     |                      | start_offset, due_limit, advance_count
//  rsp_if   | out | valid/ready          | status, out_flag_id, out_host_key, start_pos
//  csr_*    | in  | csr_we (no stall)    | csr_wdata = sample_rate
//
// From accept to next ready: queue runs the 50-step divider while it searches for the
// lowest free slot, then sums and outputs; a full table answers once the search has
// passed every slot, and a free slot found after the divider is done holds the sum back.
// Next-due and advance read one slot per cycle through the single RAM read port; clear goes straight to output.
// Reset (synchronous) empties the table and loads sample_rate 48000.
// A result waits in the output register while the next request beat is taken.
// The request side is held off while an operation is in progress.
module delayed_start_slot_scheduler #(
   parameter int SLOTS = dss_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   dss_req_if.sink                    req_if,
   dss_rsp_if.source                  rsp_if,
   input  logic                       csr_we,
   input  logic [dss_pkg::RATE_W-1:0] csr_wdata
);
   import dss_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_QUEUE,
      S_QSUM,
      S_SCAN,
      S_ADV,
      S_OUT
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [SLOTS-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              free_found_ff, free_found_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              best_found_ff, best_found_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_act_ff, rd_act_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   slot_entry_type      best_ff, best_in;
   logic [FLAG_W-1:0]   flag_ff, flag_in;
   logic [HOST_W-1:0]   host_ff, host_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   status_type          res_status_ff, res_status_in;
   logic [FLAG_W-1:0]   res_flag_ff, res_flag_in;
   logic [HOST_W-1:0]   res_host_ff, res_host_in;
   logic [POS_W-1:0]    res_pos_ff, res_pos_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [FLAG_W-1:0]   rsp_flag_ff, rsp_flag_in;
   logic [HOST_W-1:0]   rsp_host_ff, rsp_host_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;

   // datapath
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   slot_entry_type      ram_wr_entry;
   logic [ENTRY_W-1:0]  ram_rd_data;
   slot_entry_type      rd_entry;
   logic                div_start;
   logic                div_busy;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic [NUM_W-1:0]    div_quo;

   logic                req_fire;
   logic [IDX_W-1:0]    cnt_idx;
   logic                scan_end;
   logic [PROD_W-1:0]   rate_prod;
   logic [TEMPO_W-1:0]  tempo_nz;
   logic [DUE_W-2:0]    q_sat;
   logic [DUE_W-1:0]    q_sum;
   logic [DUE_W-1:0]    new_due;
   logic [DUE_W-1:0]    limit_ext;
   logic                hit;
   logic [DUE_W:0]      adv_diff;
   logic [DUE_W-1:0]    adv_due;
   logic [POS_W-1:0]    best_pos;

   assign req_fire = req_if.valid && req_if.ready;
   assign cnt_idx  = cnt_ff[IDX_W-1:0];
   assign scan_end = (cnt_ff == CNT_W'(SLOTS));
   assign rd_entry = slot_entry_type'(ram_rd_data);

   // delay conversion operands, formed in the accept cycle
   assign tempo_nz  = (req_if.tempo_mult == '0) ? TEMPO_W'(1) : req_if.tempo_mult;
   assign rate_prod = PROD_W'(req_if.delay_ms) * PROD_W'(rate_ff);
   assign div_num   = {rate_prod, {SCALE_W{1'b0}}};
   assign div_den   = DEN_W'(tempo_nz) * DEN_W'(MS_PER_S);

   // saturate the quotient, add the offset, saturate again
   assign q_sat   = (|div_quo[NUM_W-1:DUE_W-1]) ? {(DUE_W-1){1'b1}} : div_quo[DUE_W-2:0];
   assign q_sum   = {1'b0, q_sat} + DUE_W'(offset_ff);
   assign new_due = q_sum[DUE_W-1] ? DUE_MAX : q_sum;

   // next-due compare on the slot just read
   assign limit_ext = DUE_W'(limit_ff);
   assign hit = rd_vld_ff && rd_act_ff
             && ($signed(rd_entry.due) < $signed(limit_ext))
             && (!best_found_ff || ($signed(rd_entry.due) < $signed(best_ff.due)));

   // advance with saturation at the signed minimum
   assign adv_diff = {rd_entry.due[DUE_W-1], rd_entry.due} - (DUE_W+1)'(step_ff);
   assign adv_due  = (adv_diff[DUE_W] != adv_diff[DUE_W-1]) ? DUE_MIN : adv_diff[DUE_W-1:0];

   // clamp the winning due time to the start position range
   assign best_pos = best_ff.due[DUE_W-1] ? '0 :
                     ((|best_ff.due[DUE_W-2:POS_W]) ? POS_MAX : best_ff.due[POS_W-1:0]);

   always_comb begin
      state_in      = state_ff;
      rate_in       = rate_ff;
      active_in     = active_ff;
      cnt_in        = cnt_ff;
      free_found_in = free_found_ff;
      rd_vld_in     = rd_vld_ff;
      best_found_in = best_found_ff;
      rsp_valid_in  = rsp_valid_ff;
      free_idx_in   = free_idx_ff;
      rd_idx_in     = rd_idx_ff;
      rd_act_in     = rd_act_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      flag_in       = flag_ff;
      host_in       = host_ff;
      offset_in     = offset_ff;
      limit_in      = limit_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_flag_in   = res_flag_ff;
      res_host_in   = res_host_ff;
      res_pos_in    = res_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_host_in   = rsp_host_ff;
      rsp_pos_in    = rsp_pos_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = rd_idx_ff;
      ram_wr_entry  = '{flag: rd_entry.flag, host: rd_entry.host, due: adv_due};
      div_start     = 1'b0;

      if (csr_we) begin
         rate_in = csr_wdata;
      end

      // drop the result once the sink takes it
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               flag_in       = req_if.flag_id;
               host_in       = req_if.host_key;
               offset_in     = req_if.start_offset;
               limit_in      = req_if.due_limit;
               step_in       = {req_if.advance_count, {FRAC_W{1'b0}}};
               cnt_in        = '0;
               rd_vld_in     = 1'b0;
               free_found_in = 1'b0;
               best_found_in = 1'b0;
               unique case (mode_type'(req_if.mode))
                  MODE_QUEUE: begin
                     div_start = 1'b1;
                     state_in  = S_QUEUE;
                  end
                  MODE_NEXT_DUE: begin
                     state_in = S_SCAN;
                  end
                  MODE_ADVANCE: begin
                     state_in = S_ADV;
                  end
                  MODE_CLEAR: begin
                     active_in     = '0;
                     res_status_in = ST_CLEARED;
                     res_flag_in   = '0;
                     res_host_in   = '0;
                     res_pos_in    = '0;
                     state_in      = S_OUT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_QUEUE: begin
            // search for the lowest free slot while the divider runs
            if (!free_found_ff) begin
               if (scan_end) begin
                  res_status_in = ST_FULL;
                  res_flag_in   = flag_ff;
                  res_host_in   = host_ff;
                  res_pos_in    = POS_W'(offset_ff);
                  state_in      = S_OUT;
               end else if (!active_ff[cnt_idx]) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cnt_idx;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end else if (!div_busy) begin
               state_in = S_QSUM;
            end
         end

         S_QSUM: begin
            ram_wr_en              = 1'b1;
            ram_wr_addr            = free_idx_ff;
            ram_wr_entry           = '{flag: flag_ff, host: host_ff, due: new_due};
            active_in[free_idx_ff] = 1'b1;
            res_status_in          = ST_QUEUED;
            res_flag_in            = '0;
            res_host_in            = '0;
            res_pos_in             = '0;
            state_in               = S_OUT;
         end

         S_SCAN: begin
            if (!scan_end) begin
               rd_vld_in = 1'b1;
               rd_act_in = active_ff[cnt_idx];
               rd_idx_in = cnt_idx;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               rd_vld_in = 1'b0;
            end
            if (hit) begin
               best_found_in = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_in       = rd_entry;
            end
            if (scan_end && !rd_vld_ff) begin
               if (best_found_ff) begin
                  active_in[best_idx_ff] = 1'b0;
                  res_status_in          = ST_DUE;
                  res_flag_in            = best_ff.flag;
                  res_host_in            = best_ff.host;
                  res_pos_in             = best_pos;
               end else begin
                  res_status_in = ST_NONE;
                  res_flag_in   = '0;
                  res_host_in   = '0;
                  res_pos_in    = '0;
               end
               state_in = S_OUT;
            end
         end

         S_ADV: begin
            if (!scan_end) begin
               rd_vld_in = 1'b1;
               rd_act_in = active_ff[cnt_idx];
               rd_idx_in = cnt_idx;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               rd_vld_in = 1'b0;
            end
            // write back the slot read last cycle
            ram_wr_en = rd_vld_ff && rd_act_ff;
            if (scan_end && !rd_vld_ff) begin
               res_status_in = ST_ADVANCED;
               res_flag_in   = '0;
               res_host_in   = '0;
               res_pos_in    = '0;
               state_in      = S_OUT;
            end
         end

         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_flag_in   = res_flag_ff;
               rsp_host_in   = res_host_ff;
               rsp_pos_in    = res_pos_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rate_ff       <= RATE_RESET;
         active_ff     <= '0;
         cnt_ff        <= '0;
         free_found_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rate_ff       <= rate_in;
         active_ff     <= active_in;
         cnt_ff        <= cnt_in;
         free_found_ff <= free_found_in;
         rd_vld_ff     <= rd_vld_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      free_idx_ff   <= free_idx_in;
      rd_idx_ff     <= rd_idx_in;
      rd_act_ff     <= rd_act_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      flag_ff       <= flag_in;
      host_ff       <= host_in;
      offset_ff     <= offset_in;
      limit_ff      <= limit_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_flag_ff   <= res_flag_in;
      res_host_ff   <= res_host_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_host_ff   <= rsp_host_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   dss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_addr (cnt_idx),
      .rd_data (ram_rd_data)
   );

   dss_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.out_flag_id  = rsp_flag_ff;
   assign rsp_if.out_host_key = rsp_host_ff;
   assign rsp_if.start_pos    = rsp_pos_ff;

`ifndef SYNTHESIS
   // storing a queued entry takes exactly one free slot
   a_queue_fills_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_QSUM |=> $countones(active_ff) == $past($countones(active_ff)) + 1)
      else $error("queue did not occupy exactly one slot");

   // the due time is only summed once the divider has finished
   a_quotient_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_QSUM |-> !div_busy)
      else $error("quotient used while divider busy");

   // the slot picked by next-due is still occupied when it is freed
   a_best_is_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && scan_end && !rd_vld_ff && best_found_ff)
      |-> active_ff[best_idx_ff])
      else $error("next-due picked an empty slot");
`endif

endmodule

[dv/tb_delayed_start_slot_scheduler.sv]
// Self-checking testbench of the delayed start slot scheduler: directed corner cases,
// then random request beats across sample rate settings and back-pressure phases.
// Depends on dss_pkg, dss_if and the delayed_start_slot_scheduler RTL.
module tb_delayed_start_slot_scheduler;
   import dss_pkg::*;

   localparam int     SLOTS          = SLOTS_DEFAULT;
   localparam int     WATCHDOG_LIMIT = 10000;
   localparam int     BEATS_PER_RUN  = 270;
   localparam longint DUE_HI         = (longint'(1) <<< (DUE_W - 1)) - 1;
   localparam longint DUE_LO         = -DUE_HI - 1;
   localparam longint POS_HI         = (longint'(1) <<< POS_W) - 1;

   typedef struct packed {
      mode_type            mode;
      logic [FLAG_W-1:0]   flag_id;
      logic [HOST_W-1:0]   host_key;
      logic [MS_W-1:0]     delay_ms;
      logic [TEMPO_W-1:0]  tempo_mult;
      logic [OFFSET_W-1:0] start_offset;
      logic [LIMIT_W-1:0]  due_limit;
      logic [ADV_W-1:0]    advance_count;
   } sched_beat_type;

   typedef struct packed {
      status_type        status;
      logic [FLAG_W-1:0] flag_id;
      logic [HOST_W-1:0] host_key;
      logic [POS_W-1:0]  start_pos;
   } sched_result_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [RATE_W-1:0] csr_wdata;

   dss_req_if req_bus ();
   dss_rsp_if rsp_bus ();

   delayed_start_slot_scheduler #(.SLOTS(SLOTS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the slot table and the sample rate register.
   bit                tbl_busy [SLOTS];
   logic [FLAG_W-1:0] tbl_flag [SLOTS];
   logic [HOST_W-1:0] tbl_host [SLOTS];
   longint            tbl_due  [SLOTS];
   logic [RATE_W-1:0] rate_now;

   sched_beat_type   request_q [$];   // beats waiting for the driver
   sched_result_type outcome_q [$];   // predicted results, oldest first
   sched_beat_type   cur_beat;        // beat currently offered on the request channel

   int requests_open;   // beats queued but not yet taken by the block
   int errors;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_off;        // cycles the receiver still has to hold off
   int quiet_cycles;
   bit timed_out;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Apply one accepted request to the shadow table and queue the result it must cause.
   task automatic apply_request(input sched_beat_type b);
      sched_result_type  r;
      longint unsigned   num;
      longint unsigned   den;
      longint unsigned   quo;
      longint            due_t;
      longint            lim;
      longint            step;
      longint            pos;
      logic [POS_W-1:0]  pos_out;
      int                free_i;
      int                best;
      r = '{ST_QUEUED, '0, '0, '0};
      case (b.mode)
         MODE_QUEUE: begin
            free_i = -1;
            for (int i = 0; i < SLOTS; i++)
               if (!tbl_busy[i] && free_i < 0) free_i = i;
            if (free_i < 0) begin
               // Table full: start right away at the request position.
               r = '{ST_FULL, b.flag_id, b.host_key, b.start_offset};
            end else begin
               // delay = ms * rate * 2^16 / (1000 * tempo), tempo 0 taken as 1
               num = 64'(b.delay_ms);
               num = (num * 64'(rate_now)) << 16;
               den = (b.tempo_mult == '0) ? 64'd1 : 64'(b.tempo_mult);
               den = den * 64'(MS_PER_S);
               quo = num / den;
               if (quo > DUE_HI) quo = DUE_HI;
               due_t = longint'(quo);
               due_t = due_t + longint'({1'b0, b.start_offset});
               if (due_t > DUE_HI) due_t = DUE_HI;
               tbl_flag[free_i] = b.flag_id;
               tbl_host[free_i] = b.host_key;
               tbl_due[free_i]  = due_t;
               tbl_busy[free_i] = 1'b1;
            end
         end
         MODE_NEXT_DUE: begin
            lim  = longint'({1'b0, b.due_limit});
            best = -1;
            // Strict less-than keeps the lowest index on equal due times.
            for (int i = 0; i < SLOTS; i++)
               if (tbl_busy[i] && tbl_due[i] < lim)
                  if (best < 0 || tbl_due[i] < tbl_due[best]) best = i;
            if (best < 0) begin
               r.status = ST_NONE;
            end else begin
               tbl_busy[best] = 1'b0;
               pos = tbl_due[best];
               if (pos < 0) pos = 0;
               if (pos > POS_HI) pos = POS_HI;
               pos_out = pos[POS_W-1:0];
               r = '{ST_DUE, tbl_flag[best], tbl_host[best], pos_out};
            end
         end
         MODE_ADVANCE: begin
            step = longint'({1'b0, b.advance_count}) * 256;
            for (int i = 0; i < SLOTS; i++)
               if (tbl_busy[i]) begin
                  tbl_due[i] = tbl_due[i] - step;
                  if (tbl_due[i] < DUE_LO) tbl_due[i] = DUE_LO;
               end
            r.status = ST_ADVANCED;
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) tbl_busy[i] = 1'b0;
            r.status = ST_CLEARED;
         end
      endcase
      outcome_q.push_back(r);
   endtask

   // Build a beat of the given kind; fields the operation ignores stay random.
   function automatic sched_beat_type random_beat(input mode_type m);
      sched_beat_type b;
      b.mode          = m;
      b.flag_id       = FLAG_W'($urandom);
      b.host_key      = $urandom;
      b.delay_ms      = MS_W'($urandom);
      b.tempo_mult    = TEMPO_W'($urandom);
      b.start_offset  = OFFSET_W'($urandom);
      b.due_limit     = LIMIT_W'($urandom);
      b.advance_count = ADV_W'($urandom);
      case (m)
         MODE_QUEUE: begin
            case ($urandom_range(7))
               0:       b.delay_ms = '0;
               1:       b.delay_ms = '1;
               2, 3, 4: b.delay_ms = MS_W'($urandom_range(200, 1));
               default: ;
            endcase
            case ($urandom_range(15))
               0:          b.tempo_mult = '0;
               1:          b.tempo_mult = 16'd1;
               2, 3, 4, 5: b.tempo_mult = TEMPO_W'($urandom_range(320, 192));
               default:    ;
            endcase
            if ($urandom_range(15) == 0) b.start_offset = $urandom_range(1) ? '1 : '0;
         end
         MODE_NEXT_DUE: begin
            case ($urandom_range(5))
               0, 1:    b.due_limit = '1;
               2:       b.due_limit = '0;
               3:       b.due_limit = LIMIT_W'($urandom_range(16'hFFFF));
               default: ;
            endcase
         end
         MODE_ADVANCE: begin
            case ($urandom_range(7))
               0:          b.advance_count = '0;
               1:          b.advance_count = '1;
               2, 3, 4, 5: b.advance_count = ADV_W'($urandom_range(255));
               default:    ;
            endcase
         end
         default: ;
      endcase
      return b;
   endfunction

   function automatic sched_beat_type make_queue(input logic [FLAG_W-1:0] flag,
                                                 input logic [HOST_W-1:0] host,
                                                 input logic [MS_W-1:0] ms,
                                                 input logic [TEMPO_W-1:0] tempo,
                                                 input logic [OFFSET_W-1:0] offset);
      sched_beat_type b;
      b              = random_beat(MODE_QUEUE);
      b.flag_id      = flag;
      b.host_key     = host;
      b.delay_ms     = ms;
      b.tempo_mult   = tempo;
      b.start_offset = offset;
      return b;
   endfunction

   function automatic sched_beat_type make_pick(input logic [LIMIT_W-1:0] limit);
      sched_beat_type b;
      b           = random_beat(MODE_NEXT_DUE);
      b.due_limit = limit;
      return b;
   endfunction

   task automatic post(input sched_beat_type b);
      request_q.push_back(b);
      requests_open++;
   endtask

   // Hold until every queued beat is taken and every predicted result has come back.
   task automatic wait_drained();
      do @(posedge clock); while (requests_open != 0 || outcome_q.size() != 0);
   endtask

   // Request driver: predict on each accepted beat, then offer the next one unless
   // the sender idles this cycle. A held beat stays on the bus until it is taken.
   always @(posedge clock) begin : driver
      bit offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_request(cur_beat);
            requests_open--;
         end
         if (!req_bus.valid || req_bus.ready) begin
            offer = (request_q.size() > 0) && ($urandom_range(99) >= send_idle_pct);
            if (offer) begin
               cur_beat                = request_q.pop_front();
               req_bus.mode           <= cur_beat.mode;
               req_bus.flag_id        <= cur_beat.flag_id;
               req_bus.host_key       <= cur_beat.host_key;
               req_bus.delay_ms       <= cur_beat.delay_ms;
               req_bus.tempo_mult     <= cur_beat.tempo_mult;
               req_bus.start_offset   <= cur_beat.start_offset;
               req_bus.due_limit      <= cur_beat.due_limit;
               req_bus.advance_count  <= cur_beat.advance_count;
            end
            req_bus.valid <= offer;
         end
      end
   end

   // Result monitor: check each accepted beat against the oldest prediction, then
   // choose ready for the next cycle. A pending hold-off overrides random stalls.
   always @(posedge clock) begin : monitor
      sched_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outcome_q.size() == 0) begin
               $error("result beat with nothing outstanding, status %0d", rsp_bus.status);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.out_flag_id !== want.flag_id) begin
                  $error("out_flag_id: expected 'h%0h, got 'h%0h",
                         want.flag_id, rsp_bus.out_flag_id);
                  errors++;
               end
               if (rsp_bus.out_host_key !== want.host_key) begin
                  $error("out_host_key: expected 'h%0h, got 'h%0h",
                         want.host_key, rsp_bus.out_host_key);
                  errors++;
               end
               if (rsp_bus.start_pos !== want.start_pos) begin
                  $error("start_pos: expected 'h%0h, got 'h%0h",
                         want.start_pos, rsp_bus.start_pos);
                  errors++;
               end
            end
         end
         if (hold_off > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: count cycles without a beat on either channel.
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
   end

   initial begin : main
      // Drive every input to a known value before the first edge.
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_wdata             = RATE_RESET;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_QUEUE;
      req_bus.flag_id       = '0;
      req_bus.host_key      = '0;
      req_bus.delay_ms      = '0;
      req_bus.tempo_mult    = '0;
      req_bus.start_offset  = '0;
      req_bus.due_limit     = '0;
      req_bus.advance_count = '0;
      rsp_bus.ready         = 1'b0;
      rate_now              = RATE_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_busy[i] = 1'b0;
         tbl_flag[i] = '0;
         tbl_host[i] = '0;
         tbl_due[i]  = 0;
      end
      requests_open  = 0;
      errors         = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off       = 0;
      quiet_cycles   = 0;
      timed_out      = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      fork
         begin : stimulus
            sched_beat_type b;
            int             roll;
            // Directed part at the reset sample rate.
            post(make_queue('0, '0, '0, '0, '0));               // zero delay, zero tempo
            post(make_queue('1, '1, '1, 16'd1, '1));            // longest delay, top offset
            post(make_queue(16'h00A5, 32'h1234_5678, '0, 16'd256, 24'h000100));
            post(make_queue(16'h005A, 32'h8765_4321, '0, 16'd256, 24'h000100));
            post(make_pick('0));                                 // due 0 is not below 0
            post(make_pick('1));                                 // takes the zero entry
            post(make_pick('1));                                 // equal dues, lower slot
            b = random_beat(MODE_ADVANCE);
            b.advance_count = '1;
            post(b);                                             // drive one due negative
            post(make_pick(24'd1));                              // negative start clamps to 0
            post(make_pick('1));                                 // saturated entry stays above
            post(random_beat(MODE_CLEAR));
            // Fill the table, then overflow it once.
            repeat (SLOTS + 1)
               post(make_queue(FLAG_W'($urandom), $urandom, MS_W'($urandom_range(50, 1)),
                               16'd256, OFFSET_W'($urandom)));
            post(make_pick('0));
            post(random_beat(MODE_CLEAR));
            post(make_pick('1));                                 // empty table

            for (int p = 0; p < 5; p++) begin
               // Reprogram the rate only while the block is idle.
               wait_drained();
               case (p)
                  0: begin
                     csr_wdata     <= 18'd8000;
                     rate_now       = 18'd8000;
                     send_idle_pct  = 0;
                     recv_stall_pct = 0;
                  end
                  1: begin
                     csr_wdata     <= 18'd192000;
                     rate_now       = 18'd192000;
                     send_idle_pct  = 78;
                     recv_stall_pct = 0;
                  end
                  2: begin
                     csr_wdata     <= 18'd44100;
                     rate_now       = 18'd44100;
                     send_idle_pct  = 0;
                     recv_stall_pct = 78;
                  end
                  3: begin
                     rate_now       = RATE_W'($urandom_range(192000, 8000));
                     csr_wdata     <= rate_now;
                     send_idle_pct  = 31;
                     recv_stall_pct = 31;
                  end
                  default: begin
                     csr_wdata     <= 18'd96000;
                     rate_now       = 18'd96000;
                     send_idle_pct  = 0;
                     recv_stall_pct = 0;
                     hold_off       = 500;   // long stall while the sender keeps offering
                  end
               endcase
               csr_we <= 1'b1;
               @(posedge clock);
               csr_we <= 1'b0;
               // Queue the longest delay at the smallest tempo once per setting.
               post(make_queue(FLAG_W'($urandom), $urandom, '1, 16'd1, OFFSET_W'($urandom)));
               repeat (BEATS_PER_RUN) begin
                  roll = $urandom_range(99);
                  if (roll < 45)      post(random_beat(MODE_QUEUE));
                  else if (roll < 75) post(random_beat(MODE_NEXT_DUE));
                  else if (roll < 93) post(random_beat(MODE_ADVANCE));
                  else                post(random_beat(MODE_CLEAR));
               end
            end
            wait_drained();
            repeat (64) @(posedge clock);
         end
         wait (timed_out);
      join_any

      if (timed_out)
         $display("tb_delayed_start_slot_scheduler: FAIL");
      else if (errors == 0)
         $display("tb_delayed_start_slot_scheduler: PASS");
      else
         $display("tb_delayed_start_slot_scheduler: FAIL");
      $finish;
   end

endmodule
